>>> hw/rtl/mss_pkg.sv
package mss_pkg;

    typedef struct packed {
        logic [2:0] operation;
        logic [2:0] track_index;
        logic [5:0] step_index;
        logic       trig_active;
        logic [7:0] note_number;
        logic [7:0] trig_velocity;
        logic [7:0] step_count;
    } item_t;

    typedef struct packed {
        logic       event_valid;
        logic [2:0] event_track;
        logic [7:0] event_note;
        logic [7:0] event_velocity;
        logic       duck_trigger;
        logic       last_result;
    } result_t;

    // Operation codes of the input item.
    localparam logic [2:0] OP_TICK        = 3'd0;
    localparam logic [2:0] OP_PLAY        = 3'd1;
    localparam logic [2:0] OP_STOP        = 3'd2;
    localparam logic [2:0] OP_WRITE_TRIG  = 3'd3;
    localparam logic [2:0] OP_WRITE_LEN   = 3'd4;

    // Configuration register indexes.
    localparam logic REG_STEP_PERIOD = 1'b0;
    localparam logic REG_MUTE_MASK   = 1'b1;

    localparam logic [31:0] STEP_PERIOD_RESET = 32'd393216000;
    localparam logic [32:0] ONE_SAMPLE        = 33'd65536;

    localparam int MAX_RESULTS = 8;
    localparam int EV_CNT_W    = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef enum logic [2:0] {
        CMD_NOP   = 3'd0,
        CMD_TICK  = 3'd1,
        CMD_PLAY  = 3'd2,
        CMD_STOP  = 3'd3,
        CMD_TRIG  = 3'd4,
        CMD_LEN   = 3'd5
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [2:0] track;
        logic [5:0] step;
        logic       active;
        logic [7:0] note;
        logic [7:0] velocity;
        logic [7:0] length;
    } cmd_t;

    typedef struct packed {
        logic       active;
        logic [7:0] note;
        logic [7:0] velocity;
    } trig_t;

endpackage

>>> hw/rtl/mss_front.sv
module mss_front #(
    parameter int TRACKS = 8,
    parameter int STEPS  = 64
) (
    input  logic            item_valid,
    output logic            item_stall,
    input  mss_pkg::item_t  item,
    input  logic            queue_full,
    input  logic            clearing,
    output logic            push,
    output mss_pkg::cmd_t   cmd
);

    logic       track_ok;
    logic       step_ok;
    logic [7:0] clamped_len;

    assign item_stall = queue_full || clearing;
    assign push       = item_valid && !item_stall;

    assign track_ok = 32'(item.track_index) < 32'(TRACKS);
    assign step_ok  = 32'(item.step_index) < 32'(STEPS);

    always_comb
    begin
        if (item.step_count == 8'd0)
        begin
            clamped_len = 8'd1;
        end
        else if (9'(item.step_count) > 9'(STEPS))
        begin
            clamped_len = 8'(STEPS);
        end
        else
        begin
            clamped_len = item.step_count;
        end
    end

    // Writes that address a missing track or step become no-ops here, so the
    // back end never has to range-check.
    always_comb
    begin
        cmd.kind     = mss_pkg::CMD_NOP;
        cmd.track    = item.track_index;
        cmd.step     = item.step_index;
        cmd.active   = item.trig_active;
        cmd.note     = item.note_number;
        cmd.velocity = item.trig_velocity;
        cmd.length   = clamped_len;
        case (item.operation)
            mss_pkg::OP_TICK:
            begin
                cmd.kind = mss_pkg::CMD_TICK;
            end
            mss_pkg::OP_PLAY:
            begin
                cmd.kind = mss_pkg::CMD_PLAY;
            end
            mss_pkg::OP_STOP:
            begin
                cmd.kind = mss_pkg::CMD_STOP;
            end
            mss_pkg::OP_WRITE_TRIG:
            begin
                if (track_ok && step_ok)
                begin
                    cmd.kind = mss_pkg::CMD_TRIG;
                end
            end
            mss_pkg::OP_WRITE_LEN:
            begin
                if (track_ok)
                begin
                    cmd.kind = mss_pkg::CMD_LEN;
                end
            end
            default:
            begin
                cmd.kind = mss_pkg::CMD_NOP;
            end
        endcase
    end

endmodule

>>> hw/rtl/mss_queue.sv
module mss_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mss_pkg::cmd_t  push_cmd,
    output logic           full,
    output logic           q_valid,
    output mss_pkg::cmd_t  q_cmd,
    input  logic           pop
);

    mss_pkg::cmd_t                        slot_reg [mss_pkg::QUEUE_DEPTH];
    logic [mss_pkg::QUEUE_PTR_W-1:0]      wr_ptr_reg;
    logic [mss_pkg::QUEUE_PTR_W-1:0]      wr_ptr_next;
    logic [mss_pkg::QUEUE_PTR_W-1:0]      rd_ptr_reg;
    logic [mss_pkg::QUEUE_PTR_W-1:0]      rd_ptr_next;
    logic [mss_pkg::QUEUE_CNT_W-1:0]      count_reg;
    logic [mss_pkg::QUEUE_CNT_W-1:0]      count_next;
    logic                                 do_pop;

    assign full    = count_reg == mss_pkg::QUEUE_CNT_W'(mss_pkg::QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_cmd   = slot_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == mss_pkg::QUEUE_PTR_W'(mss_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mss_pkg::QUEUE_PTR_W'(mss_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hw/rtl/mss_back.sv
module mss_back #(
    parameter int TRACKS = 8,
    parameter int STEPS  = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  mss_pkg::cmd_t    q_cmd,
    output logic             q_pop,
    output logic             clearing,
    input  logic             cfg_write,
    input  logic             cfg_index,
    input  logic [31:0]      cfg_data,
    output logic             result_valid,
    input  logic             result_stall,
    output mss_pkg::result_t result
);

    localparam int TRK_W     = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int STEP_W    = $clog2(STEPS);
    localparam int LEN_W     = $clog2(STEPS + 1);
    localparam int ADDR_W    = TRK_W + STEP_W;
    localparam int MEM_DEPTH = TRACKS * (2 ** STEP_W);
    localparam int MOD_CNT_W = $clog2(LEN_W);
    localparam logic [LEN_W-1:0] RESET_LEN = LEN_W'((STEPS < 16) ? STEPS : 16);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_TICK  = 7'b0000100,
        ST_ADV   = 7'b0001000,
        ST_MOD   = 7'b0010000,
        ST_READ  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [31:0]            step_period_reg;
    logic [7:0]             mute_mask_reg;
    logic                   running_reg;
    logic                   running_next;
    logic [32:0]            acc_reg;
    logic [32:0]            acc_next;
    logic [STEP_W-1:0]      ph_reg [TRACKS];
    logic [STEP_W-1:0]      ph_next [TRACKS];
    logic [LEN_W-1:0]       len_reg [TRACKS];
    logic [LEN_W-1:0]       len_next [TRACKS];
    logic [TRK_W-1:0]       trk_reg;
    logic [TRK_W-1:0]       trk_next;
    logic [mss_pkg::EV_CNT_W-1:0] ev_cnt_reg;
    logic [mss_pkg::EV_CNT_W-1:0] ev_cnt_next;
    logic                   pend_valid_reg;
    logic                   pend_valid_next;
    mss_pkg::result_t       pend_reg;
    mss_pkg::result_t       pend_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    mss_pkg::result_t       out_reg;
    mss_pkg::result_t       out_next;
    logic [ADDR_W-1:0]      clr_reg;
    logic [ADDR_W-1:0]      clr_next;
    logic [LEN_W-1:0]       div_reg;
    logic [LEN_W-1:0]       div_next;
    logic [LEN_W-1:0]       rem_reg;
    logic [LEN_W-1:0]       rem_next;
    logic [MOD_CNT_W-1:0]   mod_cnt_reg;
    logic [MOD_CNT_W-1:0]   mod_cnt_next;

    mss_pkg::trig_t         mem [MEM_DEPTH];
    mss_pkg::trig_t         rd_data_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    mss_pkg::trig_t         mem_wdata;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_raddr;

    logic [STEP_W-1:0]      cur_ph;
    logic [LEN_W-1:0]       cur_len;
    logic [LEN_W-1:0]       inc_ph;
    logic [STEP_W-1:0]      adv_ph;
    logic [LEN_W:0]         rem_shift;
    logic [LEN_W+1:0]       rem_trial;
    logic [LEN_W-1:0]       rem_step;
    logic [32:0]            acc_inc;
    logic [33:0]            acc_diff;
    logic [4:0]             trk_wide;
    logic                   muted;
    logic                   fire;
    logic                   out_free;
    mss_pkg::result_t       empty_result;
    mss_pkg::result_t       new_event;

    assign clearing     = state_reg == ST_CLEAR;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign cur_ph  = ph_reg[trk_reg];
    assign cur_len = len_reg[trk_reg];
    assign inc_ph  = LEN_W'(cur_ph) + LEN_W'(1);
    assign adv_ph  = (inc_ph == cur_len) ? '0 : STEP_W'(inc_ph);

    // One bit of the restoring remainder per cycle, used only when a playhead
    // sits beyond a shortened length.
    assign rem_shift = {rem_reg, div_reg[LEN_W-1]};
    assign rem_trial = {1'b0, rem_shift} - {2'b00, cur_len};
    assign rem_step  = rem_trial[LEN_W+1] ? rem_shift[LEN_W-1:0] : rem_trial[LEN_W-1:0];

    assign acc_inc  = acc_reg + mss_pkg::ONE_SAMPLE;
    assign acc_diff = {1'b0, acc_reg} - {2'b00, step_period_reg};

    assign trk_wide = 5'(trk_reg);
    assign muted    = (trk_wide < 5'd8) && mute_mask_reg[trk_wide[2:0]];
    assign fire     = rd_data_reg.active && !muted
                   && (ev_cnt_reg < mss_pkg::EV_CNT_W'(mss_pkg::MAX_RESULTS));
    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        empty_result             = '0;
        empty_result.last_result = 1'b1;
        new_event.event_valid    = 1'b1;
        new_event.event_track    = 3'(trk_reg);
        new_event.event_note     = rd_data_reg.note;
        new_event.event_velocity = rd_data_reg.velocity;
        new_event.duck_trigger   = trk_reg == '0;
        new_event.last_result    = 1'b0;
    end

    always_comb
    begin
        state_next      = state_reg;
        running_next    = running_reg;
        acc_next        = acc_reg;
        ph_next         = ph_reg;
        len_next        = len_reg;
        trk_next        = trk_reg;
        ev_cnt_next     = ev_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && result_stall;
        out_next        = out_reg;
        clr_next        = clr_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        mod_cnt_next    = mod_cnt_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(MEM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop          = 1'b1;
                    out_valid_next = 1'b1;
                    out_next       = empty_result;
                    case (q_cmd.kind)
                        mss_pkg::CMD_TICK:
                        begin
                            if (running_reg)
                            begin
                                // The result comes after the period check.
                                out_valid_next = out_valid_reg && result_stall;
                                out_next       = out_reg;
                                acc_next       = acc_inc;
                                state_next     = ST_TICK;
                            end
                        end
                        mss_pkg::CMD_PLAY:
                        begin
                            running_next = 1'b1;
                            acc_next     = '0;
                        end
                        mss_pkg::CMD_STOP:
                        begin
                            running_next = 1'b0;
                            for (int t = 0; t < TRACKS; t++)
                            begin
                                ph_next[t] = '0;
                            end
                        end
                        mss_pkg::CMD_TRIG:
                        begin
                            mem_we             = 1'b1;
                            mem_waddr          = {TRK_W'(q_cmd.track), STEP_W'(q_cmd.step)};
                            mem_wdata.active   = q_cmd.active;
                            mem_wdata.note     = q_cmd.note;
                            mem_wdata.velocity = q_cmd.velocity;
                        end
                        mss_pkg::CMD_LEN:
                        begin
                            len_next[TRK_W'(q_cmd.track)] = LEN_W'(q_cmd.length);
                        end
                        default:
                        begin
                            out_next = empty_result;
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                if (!acc_diff[33])
                begin
                    acc_next    = acc_diff[32:0];
                    trk_next    = '0;
                    ev_cnt_next = '0;
                    state_next  = ST_ADV;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = empty_result;
                    state_next     = ST_IDLE;
                end
            end
            ST_ADV:
            begin
                if (inc_ph <= cur_len)
                begin
                    ph_next[trk_reg] = adv_ph;
                    mem_re           = 1'b1;
                    mem_raddr        = {trk_reg, adv_ph};
                    state_next       = ST_READ;
                end
                else
                begin
                    div_next     = inc_ph;
                    rem_next     = '0;
                    mod_cnt_next = '0;
                    state_next   = ST_MOD;
                end
            end
            ST_MOD:
            begin
                div_next     = div_reg << 1;
                rem_next     = rem_step;
                mod_cnt_next = mod_cnt_reg + 1'b1;
                if (mod_cnt_reg == MOD_CNT_W'(LEN_W - 1))
                begin
                    ph_next[trk_reg] = STEP_W'(rem_step);
                    mem_re           = 1'b1;
                    mem_raddr        = {trk_reg, STEP_W'(rem_step)};
                    state_next       = ST_READ;
                end
            end
            ST_READ:
            begin
                // An event is held back one slot so that the last one of the
                // step can carry the final-result flag.
                if (!(fire && pend_valid_reg && !out_free))
                begin
                    if (fire)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                        end
                        pend_next       = new_event;
                        pend_valid_next = 1'b1;
                        ev_cnt_next     = ev_cnt_reg + 1'b1;
                    end
                    if (trk_reg == TRK_W'(TRACKS - 1))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        trk_next   = trk_reg + 1'b1;
                        state_next = ST_ADV;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_next             = pend_reg;
                        out_next.last_result = 1'b1;
                    end
                    else
                    begin
                        out_next = empty_result;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            step_period_reg <= mss_pkg::STEP_PERIOD_RESET;
            mute_mask_reg   <= '0;
            running_reg     <= 1'b0;
            acc_reg         <= '0;
            for (int t = 0; t < TRACKS; t++)
            begin
                ph_reg[t]  <= '0;
                len_reg[t] <= RESET_LEN;
            end
            trk_reg         <= '0;
            ev_cnt_reg      <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            clr_reg         <= '0;
            mod_cnt_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            running_reg    <= running_next;
            acc_reg        <= acc_next;
            ph_reg         <= ph_next;
            len_reg        <= len_next;
            trk_reg        <= trk_next;
            ev_cnt_reg     <= ev_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            clr_reg        <= clr_next;
            mod_cnt_reg    <= mod_cnt_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    mss_pkg::REG_STEP_PERIOD:
                    begin
                        step_period_reg <= cfg_data;
                    end
                    mss_pkg::REG_MUTE_MASK:
                    begin
                        mute_mask_reg <= cfg_data[7:0];
                    end
                    default:
                    begin
                        mute_mask_reg <= mute_mask_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

>>> hw/rtl/multitrack_step_sequencer.sv
// Channel   Direction  Handshake                     Payload
// item      in         item_valid / item_stall       item (mss_pkg::item_t)
// result    out        result_valid / result_stall   result (mss_pkg::result_t)
// cfg       in         cfg_valid / cfg_ready         cfg_index, cfg_data
//
// Requests wait in a two-entry queue. A tick while running is checked against the period first;
// a tick that takes a step walks the tracks one by one through the one read port of the trig
// memory, with a restoring remainder division for each track whose playhead lies beyond a
// shortened length, and result_stall can hold back any result.
// After reset the trig memory clears all TRACKS * 2**clog2(STEPS) entries (512 by default)
// with item_stall high; cfg writes are taken meanwhile.
module multitrack_step_sequencer #(
    parameter int TRACKS = 8,
    parameter int STEPS  = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  mss_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output mss_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [31:0]      cfg_data
);

    logic           queue_full;
    logic           clearing;
    logic           push;
    mss_pkg::cmd_t  push_cmd;
    logic           q_valid;
    mss_pkg::cmd_t  q_cmd;
    logic           q_pop;

    assign cfg_ready = 1'b1;

    mss_front #(
        .TRACKS (TRACKS),
        .STEPS  (STEPS)
    ) u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .queue_full (queue_full),
        .clearing   (clearing),
        .push       (push),
        .cmd        (push_cmd)
    );

    mss_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (q_pop)
    );

    mss_back #(
        .TRACKS (TRACKS),
        .STEPS  (STEPS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

import mss_pkg::*;

class note_event_scoreboard;
    localparam int TRACK_COUNT = 8;
    localparam int STEP_COUNT  = 64;

    trig_t       pattern [TRACK_COUNT][STEP_COUNT];
    logic [6:0]  track_len [TRACK_COUNT];
    logic [5:0]  head [TRACK_COUNT];
    logic [32:0] accum;
    bit          playing;
    logic [31:0] period;
    logic [7:0]  muted;

    result_t     expected_events [$];
    int          failures;
    int          requests;
    int          checked;
    int          note_ons;
    int          ducks;

    function new();
        foreach (pattern[t, s])
            pattern[t][s] = '0;
        foreach (track_len[t])
        begin
            track_len[t] = 7'd16;
            head[t] = '0;
        end
        accum = '0;
        playing = 1'b0;
        period = STEP_PERIOD_RESET;
        muted = '0;
        failures = 0;
        requests = 0;
        checked = 0;
        note_ons = 0;
        ducks = 0;
    endfunction

    function void set_register(logic idx, logic [31:0] data);
        if (idx == REG_STEP_PERIOD)
            period = data;
        else
            muted = data[7:0];
    endfunction

    // Works out the note-on events that one accepted request causes.
    function void note_request(item_t req);
        result_t batch [$];
        result_t ev;
        requests++;
        case (req.operation)
            OP_TICK:
            begin
                if (playing)
                begin
                    accum = accum + ONE_SAMPLE;
                    if (accum >= {1'b0, period})
                    begin
                        accum = accum - {1'b0, period};
                        for (int t = 0; t < TRACK_COUNT; t++)
                        begin
                            // A playhead past a shortened length wraps only here.
                            head[t] = 6'((int'(head[t]) + 1) % int'(track_len[t]));
                            if (pattern[t][head[t]].active && !muted[t])
                            begin
                                ev = '0;
                                ev.event_valid = 1'b1;
                                ev.event_track = 3'(t);
                                ev.event_note = pattern[t][head[t]].note;
                                ev.event_velocity = pattern[t][head[t]].velocity;
                                ev.duck_trigger = (t == 0);
                                batch.push_back(ev);
                            end
                        end
                    end
                end
            end
            OP_PLAY:
            begin
                playing = 1'b1;
                accum = '0;
            end
            OP_STOP:
            begin
                playing = 1'b0;
                foreach (head[t])
                    head[t] = '0;
            end
            OP_WRITE_TRIG:
                pattern[req.track_index][req.step_index] =
                    {req.trig_active, req.note_number, req.trig_velocity};
            OP_WRITE_LEN:
            begin
                if (req.step_count == 0)
                    track_len[req.track_index] = 7'd1;
                else if (req.step_count > STEP_COUNT)
                    track_len[req.track_index] = 7'(STEP_COUNT);
                else
                    track_len[req.track_index] = req.step_count[6:0];
            end
            default:
            begin
            end
        endcase
        if (batch.size() == 0)
        begin
            ev = '0;
            batch.push_back(ev);
        end
        ev = batch.pop_back();
        ev.last_result = 1'b1;
        batch.push_back(ev);
        foreach (batch[i])
            expected_events.push_back(batch[i]);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t  %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            failures++;
        end
    endfunction

    function void check_result(result_t got);
        result_t want;
        checked++;
        if (got.event_valid)
            note_ons++;
        if (got.duck_trigger)
            ducks++;
        if (expected_events.size() == 0)
        begin
            $display("%0t  unexpected result: expected none, actual %h", $time, got);
            failures++;
            return;
        end
        want = expected_events.pop_front();
        compare_field("event_valid", want.event_valid, got.event_valid);
        compare_field("event_track", want.event_track, got.event_track);
        compare_field("event_note", want.event_note, got.event_note);
        compare_field("event_velocity", want.event_velocity, got.event_velocity);
        compare_field("duck_trigger", want.duck_trigger, got.duck_trigger);
        compare_field("last_result", want.last_result, got.last_result);
    endfunction
endclass

module testbench;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    item_t       item;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    logic [31:0] phase_period [8] = '{32'd65536, 32'd98304, 32'd32768, 32'hFFFF_FFFF,
                                      32'd65536, 32'd65536, 32'd131072, 32'd65536};
    logic [7:0]  phase_mute [8] = '{8'h00, 8'hA5, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h01, 8'h80};

    note_event_scoreboard sb;

    multitrack_step_sequencer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("FAIL");
        $finish;
    end

    always @(negedge clk)
        result_stall <= ($urandom_range(0, 99) < receiver_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_register(cfg_index, cfg_data);
            if (item_valid && !item_stall)
                sb.note_request(item);
            if (result_valid && !result_stall)
                sb.check_result(result);
        end
    end

    function automatic item_t make_request(logic [2:0] op, logic [2:0] trk, logic [5:0] stp,
                                           logic act, logic [7:0] note, logic [7:0] vel,
                                           logic [7:0] cnt);
        item_t req;
        req.operation = op;
        req.track_index = trk;
        req.step_index = stp;
        req.trig_active = act;
        req.note_number = note;
        req.trig_velocity = vel;
        req.step_count = cnt;
        return req;
    endfunction

    // Entered and left at a falling edge; valid stays high after acceptance.
    task automatic send_request(input item_t req);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item <= req;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
    endtask

    task automatic write_settings(input logic [31:0] period, input logic [7:0] mask);
        cfg_index <= REG_STEP_PERIOD;
        cfg_data <= period;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_index <= REG_MUTE_MASK;
        cfg_data <= {24'd0, mask};
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        item_valid <= 1'b0;
        while (sb.expected_events.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        item_t req;
        int    sent;
        int    roll;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_STEP_PERIOD;
        cfg_data = '0;
        sb = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Register writes are taken while the trig memory is still clearing.
        write_settings(32'd65536, 8'h00);

        send_request(make_request(OP_TICK, 3'd0, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0));
        send_request(make_request(OP_WRITE_TRIG, 3'd0, 6'd1, 1'b1, 8'd255, 8'd255, 8'd0));
        send_request(make_request(OP_WRITE_TRIG, 3'd7, 6'd63, 1'b1, 8'd0, 8'd0, 8'd0));
        send_request(make_request(OP_WRITE_TRIG, 3'd3, 6'd1, 1'b1, 8'hA5, 8'h5A, 8'd0));
        send_request(make_request(OP_WRITE_TRIG, 3'd5, 6'd2, 1'b0, 8'd255, 8'd255, 8'd0));
        send_request(make_request(OP_WRITE_TRIG, 3'd7, 6'd0, 1'b1, 8'h3C, 8'hC3, 8'd0));
        send_request(make_request(OP_WRITE_LEN, 3'd7, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0));
        send_request(make_request(OP_WRITE_LEN, 3'd6, 6'd0, 1'b0, 8'd0, 8'd0, 8'd255));
        send_request(make_request(OP_WRITE_LEN, 3'd2, 6'd0, 1'b0, 8'd0, 8'd0, 8'd64));
        send_request(make_request(OP_PLAY, 3'd0, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0));
        send_request(make_request(OP_TICK, 3'd0, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0));
        send_request(make_request(OP_TICK, 3'd0, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0));
        for (int code = OP_WRITE_LEN + 1; code < 8; code++)
            send_request(make_request(3'(code), 3'd7, 6'd63, 1'b1, 8'd255, 8'd255, 8'd255));
        send_request(make_request(OP_STOP, 3'd0, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0));
        send_request(make_request(OP_TICK, 3'd0, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0));
        send_request(make_request(OP_PLAY, 3'd0, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0));
        send_request(make_request(OP_TICK, 3'd0, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0));
        send_request(make_request(OP_WRITE_TRIG, 3'd6, 6'd63, 1'b1, 8'd255, 8'd0, 8'd0));
        // Track 0 sits on step 1 and now gets a length of one.
        send_request(make_request(OP_WRITE_LEN, 3'd0, 6'd0, 1'b0, 8'd0, 8'd0, 8'd1));
        send_request(make_request(OP_TICK, 3'd0, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0));
        send_request(make_request(OP_WRITE_LEN, 3'd7, 6'd0, 1'b0, 8'd0, 8'd0, 8'd64));
        send_request(make_request(OP_STOP, 3'd0, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0));

        for (int phase = 0; phase < 8; phase++)
        begin
            drain();
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 49; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 49; end
                default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
            endcase
            if (phase == 4)
                write_settings($urandom_range(65536, 200000), 8'($urandom_range(0, 255)));
            else
                write_settings(phase_period[phase], phase_mute[phase]);
            send_request(make_request(OP_PLAY, 3'd0, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0));
            sent = 1;
            while (sent < 37)
            begin
                roll = $urandom_range(0, 99);
                req.track_index = 3'($urandom_range(0, 7));
                req.step_index = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                             : 6'($urandom_range(0, 15));
                req.trig_active = ($urandom_range(0, 4) != 0);
                req.note_number = 8'($urandom_range(0, 255));
                req.trig_velocity = 8'($urandom_range(0, 255));
                case ($urandom_range(0, 9))
                    0: req.step_count = 8'd0;
                    1: req.step_count = 8'd255;
                    2: req.step_count = 8'($urandom_range(0, 255));
                    default: req.step_count = 8'($urandom_range(1, 16));
                endcase
                if (roll < 50)
                    req.operation = OP_TICK;
                else if (roll < 72)
                    req.operation = OP_WRITE_TRIG;
                else if (roll < 82)
                    req.operation = OP_WRITE_LEN;
                else if (roll < 89)
                    req.operation = OP_PLAY;
                else if (roll < 93)
                    req.operation = OP_STOP;
                else
                    req.operation = 3'($urandom_range(OP_WRITE_LEN + 1, 7));
                send_request(req);
                if (req.operation <= OP_WRITE_LEN)
                    sent++;
            end
        end

        drain();
        repeat (100) @(posedge clk);
        $display("Ran %0d requests through eight register settings, including the period extremes,",
                 sb.requests);
        $display("under four idle mixes; %0d results checked, %0d note-ons, %0d with duck set.",
                 sb.checked, sb.note_ons, sb.ducks);
        if (sb.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/mss_pkg.sv
hw/rtl/mss_front.sv
hw/rtl/mss_queue.sv
hw/rtl/mss_back.sv
hw/rtl/multitrack_step_sequencer.sv
verif/testbench.sv
